/* design/lc3_instruction_execute_unit_macros.svh */
// Assertion helpers for the LC-3 execute unit.
`ifndef LC3_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define LC3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LC3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* design/lc3ex_pkg.sv */
package lc3ex_pkg;
   localparam int MemWords = 65536;
   localparam int MemAw = $clog2(MemWords);
   localparam logic [15:0] KbsrAddr = 16'hFE00;
   localparam logic [15:0] KbdrAddr = 16'hFE02;
   localparam logic [15:0] KeyReady = 16'h8000;

   localparam logic [1:0] ModeExec = 2'd0;
   localparam logic [1:0] ModeMemWr = 2'd1;
   localparam logic [1:0] ModeSetPc = 2'd2;

   localparam logic [3:0] OpBr = 4'd0, OpAdd = 4'd1, OpLd = 4'd2, OpSt = 4'd3,
      OpJsr = 4'd4, OpAnd = 4'd5, OpLdr = 4'd6, OpStr = 4'd7, OpRti = 4'd8,
      OpNot = 4'd9, OpLdi = 4'd10, OpSti = 4'd11, OpJmp = 4'd12, OpRes = 4'd13,
      OpLea = 4'd14, OpTrap = 4'd15;

   localparam logic [2:0] CcNeg = 3'd4, CcZero = 3'd2, CcPos = 3'd1;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      if (v == 16'd0) return CcZero;
      if (v[15]) return CcNeg;
      return CcPos;
   endfunction
endpackage

/* design/lc3ex_mem.sv */
// Word memory, one port, synchronous read; read data is registered.
module lc3ex_mem (
   input  logic clock,
   input  logic wr_en,
   input  logic [lc3ex_pkg::MemAw-1:0] addr,
   input  logic [15:0] wr_data,
   output logic [15:0] rd_data
);
   import lc3ex_pkg::*;
   logic [15:0] mem [MemWords];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* design/lc3_instruction_execute_unit.sv */
// LC-3 instruction execute unit.
// Input channel (req_*): one word per item. mode 0 executes req_word as an
// LC-3 instruction, mode 1 stores req_word at req_address, mode 2 loads the
// PC from req_address. req_key_ready / req_key_char feed keyboard status reads.
// Result channel (rsp_*): one word per item with PC, NZP, register write and
// memory write reports and the unsupported flag.
// Sequencing: ALU ops, branches, jumps, LEA, ST/STR and modes 1-3 go straight
// to the output register. LD, LDR and STI pass through S_RD1 (one memory read;
// STI then writes through the pointer). LDI passes through S_RD1 and S_RD2 (two
// dependent reads of the single-port memory). The next item enters once the
// sequencer is back at its first step and the output register is empty or
// being drained in that same cycle.
// Reset: registers, PC and keyboard data register clear, NZP becomes Z (010).
// The word memory is not cleared; reading an unwritten word yields junk.
// Stall: a held result blocks the input; the finished word holds steady until
// taken, so at most one word waits.
module lc3_instruction_execute_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_mode,
   input  logic [15:0] req_word,
   input  logic [15:0] req_address,
   input  logic req_key_ready,
   input  logic [7:0] req_key_char,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_pc_after,
   output logic [2:0] rsp_cond_code,
   output logic rsp_reg_written,
   output logic [2:0] rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic rsp_mem_written,
   output logic [15:0] rsp_mem_address,
   output logic [15:0] rsp_mem_value,
   output logic rsp_unsupported
);
   import lc3ex_pkg::*;
   `include "lc3_instruction_execute_unit_macros.svh"

   typedef enum logic [1:0] {S_IDLE, S_RD1, S_RD2} state_type;

   state_type state_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff;
   logic [2:0] cc_ff;
   // status register is rebuilt from the key input on every read, so only
   // the data register needs a copy
   logic [15:0] kbdr_ff;
   // held item while memory reads are in flight
   logic [15:0] iw_ff;
   logic key_rdy_ff;
   logic [7:0] key_ch_ff;
   logic [15:0] raddr_ff;   // address of outstanding read
   logic [15:0] pc_inc_ff;

   logic out_free;
   assign out_free = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   logic acc;
   assign acc = req_valid && req_ready;

   // decode of the incoming word
   logic [3:0] op;
   logic [2:0] dr, sr1, sr2;
   logic [15:0] pc1, s5, s6, s9, s11, pcoff, baseoff, opnd, a_sr1;
   assign op = req_word[15:12];
   assign dr = req_word[11:9];
   assign sr1 = req_word[8:6];
   assign sr2 = req_word[2:0];
   assign pc1 = pc_ff + 16'd1;
   assign s5 = {{11{req_word[4]}}, req_word[4:0]};
   assign s6 = {{10{req_word[5]}}, req_word[5:0]};
   assign s9 = {{7{req_word[8]}}, req_word[8:0]};
   assign s11 = {{5{req_word[10]}}, req_word[10:0]};
   assign a_sr1 = regs_ff[sr1];
   assign pcoff = pc1 + s9;
   assign baseoff = a_sr1 + s6;
   assign opnd = req_word[5] ? s5 : regs_ff[sr2];

   // memory port
   logic mem_we;
   logic [15:0] mem_a, mem_wd, mem_rd;
   lc3ex_mem u_mem (.clock(clock), .wr_en(mem_we), .addr(mem_a[MemAw-1:0]),
      .wr_data(mem_wd), .rd_data(mem_rd));

   // value returned by the outstanding read (keyboard registers override)
   logic [15:0] rd_val;
   always_comb begin
      priority if (raddr_ff == KbsrAddr) rd_val = key_rdy_ff ? KeyReady : 16'd0;
      else if (raddr_ff == KbdrAddr) rd_val = kbdr_ff;
      else rd_val = mem_rd;
   end

   // sequencer-held opcode
   logic [3:0] hop;
   logic [2:0] hdr;
   assign hop = iw_ff[15:12];
   assign hdr = iw_ff[11:9];

   // issue a read at start (LD, LDR, LDI, STI) ; STI final write; ST/STR/mode1
   logic start_rd;
   logic [15:0] start_ra;
   always_comb begin
      start_rd = 1'b0;
      start_ra = pcoff;
      if (req_mode == ModeExec) begin
         unique case (op)
            OpLd, OpLdi, OpSti: start_rd = 1'b1;
            OpLdr: begin start_rd = 1'b1; start_ra = baseoff; end
            default: ;
         endcase
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_a = start_ra;
      mem_wd = req_word;
      if (state_ff == S_IDLE) begin
         if (acc && req_mode == ModeMemWr) begin
            mem_a = req_address;
            mem_we = (req_address != KbsrAddr) && (req_address != KbdrAddr);
         end else if (acc && req_mode == ModeExec && (op == OpSt || op == OpStr)) begin
            mem_a = (op == OpSt) ? pcoff : baseoff;
            mem_wd = regs_ff[dr];
            mem_we = (mem_a != KbsrAddr) && (mem_a != KbdrAddr);
         end
      end else if (state_ff == S_RD1 && (hop == OpLdi || hop == OpSti)) begin
         // second access: address came back from the first read
         mem_a = rd_val;
         mem_wd = regs_ff[hdr];
         mem_we = (hop == OpSti) && (rd_val != KbsrAddr) && (rd_val != KbdrAddr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         pc_ff <= 16'd0;
         cc_ff <= CcZero;
         kbdr_ff <= 16'd0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (acc) begin
               rsp_reg_written <= 1'b0; rsp_reg_index <= 3'd0; rsp_reg_value <= 16'd0;
               rsp_mem_written <= 1'b0; rsp_mem_address <= 16'd0;
               rsp_mem_value <= 16'd0; rsp_unsupported <= 1'b0;
               rsp_pc_after <= pc_ff; rsp_cond_code <= cc_ff;
               iw_ff <= req_word; key_rdy_ff <= req_key_ready;
               key_ch_ff <= req_key_char; raddr_ff <= start_ra; pc_inc_ff <= pc1;
               if (req_mode == ModeMemWr) begin
                  rsp_valid <= 1'b1;
                  rsp_mem_written <= 1'b1; rsp_mem_address <= req_address;
                  rsp_mem_value <= req_word;
                  if (req_address == KbdrAddr) kbdr_ff <= req_word;
               end else if (req_mode == ModeSetPc) begin
                  rsp_valid <= 1'b1; pc_ff <= req_address; rsp_pc_after <= req_address;
               end else if (req_mode != ModeExec) begin
                  rsp_valid <= 1'b1;
               end else if (op == OpRti || op == OpRes || op == OpTrap) begin
                  rsp_valid <= 1'b1; rsp_unsupported <= 1'b1;
               end else if (start_rd) begin
                  state_ff <= S_RD1; pc_ff <= pc1;
               end else begin
                  logic [15:0] npc, rv;
                  logic wr;
                  npc = pc1; rv = 16'd0; wr = 1'b0;
                  unique case (op)
                     OpBr: if ((dr & cc_ff) != 3'd0) npc = pcoff;
                     OpAdd: begin rv = a_sr1 + opnd; wr = 1'b1; end
                     OpAnd: begin rv = a_sr1 & opnd; wr = 1'b1; end
                     OpNot: begin rv = ~a_sr1; wr = 1'b1; end
                     OpLea: begin rv = pcoff; wr = 1'b1; end
                     OpJmp: npc = a_sr1;
                     OpJsr: npc = req_word[11] ? pc1 + s11 : a_sr1;
                     default: ;
                  endcase
                  rsp_valid <= 1'b1;
                  pc_ff <= npc; rsp_pc_after <= npc;
                  if (op == OpJsr) begin
                     regs_ff[7] <= pc1;
                     rsp_reg_written <= 1'b1; rsp_reg_index <= 3'd7; rsp_reg_value <= pc1;
                  end else if (wr) begin
                     regs_ff[dr] <= rv; cc_ff <= flags_of(rv);
                     rsp_cond_code <= flags_of(rv);
                     rsp_reg_written <= 1'b1; rsp_reg_index <= dr; rsp_reg_value <= rv;
                  end else if (op == OpSt || op == OpStr) begin
                     rsp_mem_written <= 1'b1; rsp_mem_address <= mem_a;
                     rsp_mem_value <= regs_ff[dr];
                     if (mem_a == KbdrAddr) kbdr_ff <= regs_ff[dr];
                  end
               end
            end
            S_RD1: begin
               rsp_pc_after <= pc_inc_ff;
               if (raddr_ff == KbsrAddr && key_rdy_ff) kbdr_ff <= {8'd0, key_ch_ff};
               if (hop == OpLdi) begin
                  state_ff <= S_RD2; raddr_ff <= rd_val;
               end else if (hop == OpSti) begin
                  state_ff <= S_IDLE; rsp_valid <= 1'b1;
                  rsp_mem_written <= 1'b1; rsp_mem_address <= rd_val;
                  rsp_mem_value <= regs_ff[hdr];
                  if (rd_val == KbdrAddr) kbdr_ff <= regs_ff[hdr];
               end else begin
                  state_ff <= S_IDLE; rsp_valid <= 1'b1;
                  regs_ff[hdr] <= rd_val; cc_ff <= flags_of(rd_val);
                  rsp_cond_code <= flags_of(rd_val);
                  rsp_reg_written <= 1'b1; rsp_reg_index <= hdr; rsp_reg_value <= rd_val;
               end
            end
            S_RD2: begin
               // the pointer may itself name the status register
               logic [15:0] v;
               v = rd_val;
               if (raddr_ff == KbsrAddr && key_rdy_ff) kbdr_ff <= {8'd0, key_ch_ff};
               state_ff <= S_IDLE; rsp_valid <= 1'b1;
               regs_ff[hdr] <= v; cc_ff <= flags_of(v);
               rsp_cond_code <= flags_of(v);
               rsp_reg_written <= 1'b1; rsp_reg_index <= hdr; rsp_reg_value <= v;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LC3_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE,
      "ready outside idle")
   `LC3_ASSERT_NEXT(a_rd1_done, clock, reset,
      state_ff == S_RD1 && hop != OpLdi, state_ff == S_IDLE && rsp_valid,
      "single read did not finish")
   `LC3_ASSERT_IMPL(a_busy_out_free, clock, reset, state_ff != S_IDLE, !rsp_valid,
      "result pending while a read is in flight")
   `LC3_ASSERT_IMPL(a_one_write, clock, reset, rsp_valid,
      !(rsp_reg_written && rsp_mem_written), "register and memory write together")
endmodule
